### src/dnf_pkg.sv
// dnf_pkg: shared sizes and types for the duplicate nonce filter.
// No dependencies; imported by dnf_ctrl, duplicate_nonce_filter_unit and the testbench.
`timescale 1ns / 1ps
package dnf_pkg;

	localparam int HISTORY_DEPTH = 2048;
	localparam int NONCE_W       = 32;
	localparam int ADDR_W        = $clog2(HISTORY_DEPTH);
	localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

	// result handed from the sequencer to the output register
	typedef struct packed {
		logic valid;
		logic is_new;
	} dnf_result_t;

endpackage

### src/dnf_ram.sv
// dnf_ram: generic one-write, one-read memory with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module dnf_ram #(
	parameter int DEPTH  = 2048,
	parameter int WIDTH  = 32,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/dnf_ctrl.sv
// dnf_ctrl: scan sequencer and shared 32-bit comparator over the nonce history.
// Depends on dnf_pkg and dnf_ram.
`timescale 1ns / 1ps
module dnf_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [dnf_pkg::NONCE_W-1:0]  nonce,
	output logic                         idle,
	input  logic                         out_free,
	output dnf_pkg::dnf_result_t         result
);
	import dnf_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(HISTORY_DEPTH);
	localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(HISTORY_DEPTH - 1);

	logic [1:0]         state_q;
	logic [NONCE_W-1:0] nonce_q;
	logic [CNT_W-1:0]   fill_q;
	logic [ADDR_W-1:0]  oldest_q;
	logic [CNT_W-1:0]   scan_q;
	logic               pend_q;
	logic               hit_q;

	logic               hit_now;
	logic               scan_end;
	logic               rd_en;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	logic [NONCE_W-1:0] rd_data;
	logic               full;

	// history storage
	dnf_ram #(
		.DEPTH  (HISTORY_DEPTH),
		.WIDTH  (NONCE_W),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (nonce_q),
		.re    (rd_en),
		.raddr (scan_q[ADDR_W-1:0]),
		.rdata (rd_data)
	);

	// shared compare on the entry read last cycle
	assign hit_now  = pend_q && (rd_data == nonce_q);
	assign scan_end = (scan_q == fill_q);
	assign full     = (fill_q == FULL_CNT);
	// oldest_q stays 0 until full, so valid entries sit at 0..fill-1
	assign rd_en    = (state_q == ST_SCAN) && !scan_end && !hit_q && !hit_now;
	assign wr_en    = (state_q == ST_DONE) && out_free && !hit_q;
	assign wr_addr  = full ? oldest_q : fill_q[ADDR_W-1:0];

	assign idle          = (state_q == ST_IDLE);
	assign result.valid  = (state_q == ST_DONE) && out_free;
	assign result.is_new = !hit_q;

	// capture nonce on start
	always_ff @(posedge clk) begin
		if (start && idle) begin
			nonce_q <= nonce;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			oldest_q <= '0;
			scan_q   <= '0;
			pend_q   <= 1'b0;
			hit_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					pend_q <= 1'b0;
					if (start) begin
						scan_q  <= '0;
						hit_q   <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (hit_now) begin
						hit_q <= 1'b1;
					end
					pend_q <= rd_en;
					if (rd_en) begin
						scan_q <= scan_q + 1'b1;
					end
					// finish once nothing is in flight and the scan is over or has hit
					if (!pend_q && (scan_end || hit_q)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						if (!hit_q) begin
							if (full) begin
								oldest_q <= (oldest_q == LAST_SLOT) ? '0
									: oldest_q + 1'b1;
							end else begin
								fill_q <= fill_q + 1'b1;
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### src/duplicate_nonce_filter_unit.sv
// duplicate_nonce_filter_unit: top level of the duplicate nonce filter.
// Depends on dnf_pkg and dnf_ctrl (which holds dnf_ram).
//
//   channel | signals                                | payload
//   --------+----------------------------------------+--------------------
//   input   | in_valid / in_ready                    | packet_nonce [31:0]
//   output  | out_valid / out_ready                  | is_new
//
// The scan reads one history entry per cycle through the single RAM read
// port.
// A match ends the scan early. Reset clears the fill count and oldest slot;
// the history RAM itself is not cleared. A new beat is accepted while a
// result still waits; the sequencer holds its result until out_ready frees
// the output register.
`timescale 1ns / 1ps
module duplicate_nonce_filter_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [dnf_pkg::NONCE_W-1:0]  packet_nonce,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         is_new
);
	import dnf_pkg::*;

	logic        out_valid_q;
	logic        is_new_q;
	logic        idle;
	logic        out_free;
	dnf_result_t result;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = idle;

	dnf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_valid),
		.nonce    (packet_nonce),
		.idle     (idle),
		.out_free (out_free),
		.result   (result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result.valid) begin
			is_new_q <= result.is_new;
		end
	end

	assign out_valid = out_valid_q;
	assign is_new    = is_new_q;

endmodule

### verif/tb_duplicate_nonce_filter_unit.sv
// tb_duplicate_nonce_filter_unit: self-checking testbench for the duplicate nonce filter.
// It keeps its own scoreboard model of the nonce history, covering FIFO eviction once the
// history is full. Depends on dnf_pkg and duplicate_nonce_filter_unit.
`timescale 1ns / 1ps
module tb_duplicate_nonce_filter_unit;
	import dnf_pkg::*;

	localparam int IDLE_LIMIT  = 12000;
	localparam int TAIL_CYCLES = HISTORY_DEPTH + 64;

	typedef struct packed {
		logic [NONCE_W-1:0] nonce;
		logic               is_new;
	} nonce_verdict_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [NONCE_W-1:0] packet_nonce = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               is_new;

	duplicate_nonce_filter_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.packet_nonce (packet_nonce),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.is_new       (is_new)
	);

	// scoreboard copy of the history, oldest entry first
	logic [NONCE_W-1:0] seen_nonces [HISTORY_DEPTH];
	int                 seen_oldest = 0;
	int                 seen_fill = 0;
	logic [NONCE_W-1:0] evicted_nonces [$];

	logic [NONCE_W-1:0] pending_nonces [$];
	logic [NONCE_W-1:0] sent_nonces [$];
	nonce_verdict_t     expected_verdicts [$];
	int                 beats_in_flight = 0;
	int                 results_seen = 0;
	int                 mismatches = 0;
	int                 idle_cycles = 0;
	int                 send_gap = 0;
	int                 recv_stall = 0;
	bit                 send_burst = 1'b0;
	bit                 recv_burst = 1'b0;

	// zero, all ones, single-bit and near-miss values, some of them repeated
	logic [NONCE_W-1:0] corner_nonces [17] = '{
		32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
		32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
		32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h0000_FFFF, 32'hFFFF_0000,
		32'h0000_FFFF, 32'hFFFF_FFFF
	};

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Look the nonce up in the history; record it when absent. Returns the is_new verdict.
	function automatic bit record_nonce(input logic [NONCE_W-1:0] nonce);
		int slot;
		slot = seen_oldest;
		for (int n = 0; n < seen_fill; n++) begin
			if (seen_nonces[slot] == nonce)
				return 1'b0;
			slot = (slot + 1) % HISTORY_DEPTH;
		end
		if (seen_fill < HISTORY_DEPTH) begin
			seen_nonces[(seen_oldest + seen_fill) % HISTORY_DEPTH] = nonce;
			seen_fill++;
		end else begin
			// full: overwrite the oldest entry
			evicted_nonces.push_back(seen_nonces[seen_oldest]);
			seen_nonces[seen_oldest] = nonce;
			seen_oldest = (seen_oldest + 1) % HISTORY_DEPTH;
		end
		return 1'b1;
	endfunction

	// mostly no gap, some short, a few long
	function automatic int draw_idle(input bit burst);
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 90);
	endfunction

	// repeats of recent nonces, one-bit near misses, bit patterns and fresh values
	function automatic logic [NONCE_W-1:0] mixed_nonce();
		int r;
		int depth;
		logic [NONCE_W-1:0] recent;
		r = $urandom_range(0, 99);
		depth = (sent_nonces.size() > 32) ? 32 : sent_nonces.size();
		if (depth > 0)
			recent = sent_nonces[sent_nonces.size() - 1 - $urandom_range(0, depth - 1)];
		else
			recent = $urandom();
		if (r < 40)
			return recent;
		if (r < 50)
			return recent ^ (32'h1 << $urandom_range(0, NONCE_W - 1));
		if (r < 60) begin
			case ($urandom_range(0, 3))
				0: return 32'h1 << $urandom_range(0, NONCE_W - 1);
				1: return ~(32'h1 << $urandom_range(0, NONCE_W - 1));
				2: return '0;
				default: return '1;
			endcase
		end
		return $urandom();
	endfunction

	// hit the oldest, newest and other history entries, revive evicted ones if any
	function automatic logic [NONCE_W-1:0] full_history_nonce();
		int r;
		int depth;
		r = $urandom_range(0, 99);
		if (r < 25)
			return seen_nonces[(seen_oldest + $urandom_range(0, 3)) % HISTORY_DEPTH];
		if (r < 40)
			return seen_nonces[(seen_oldest + seen_fill - 1 - $urandom_range(0, 3)) % HISTORY_DEPTH];
		if (r < 50)
			return seen_nonces[(seen_oldest + $urandom_range(0, seen_fill - 1)) % HISTORY_DEPTH];
		if (r < 70 && evicted_nonces.size() > 0) begin
			depth = (evicted_nonces.size() > 4) ? 4 : evicted_nonces.size();
			return evicted_nonces[evicted_nonces.size() - 1 - $urandom_range(0, depth - 1)];
		end
		return mixed_nonce();
	endfunction

	task automatic queue_nonce(input logic [NONCE_W-1:0] nonce);
		pending_nonces.push_back(nonce);
		sent_nonces.push_back(nonce);
		beats_in_flight++;
	endtask

	task automatic wait_drained();
		while (beats_in_flight > 0)
			@(posedge clk);
	endtask

	// Driver: presents queued nonces, random gaps between beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid     <= 1'b0;
			packet_nonce <= '0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				expected_verdicts.push_back({packet_nonce, record_nonce(packet_nonce)});
				if ($urandom_range(0, 39) == 0)
					send_burst = !send_burst;
				send_gap = draw_idle(send_burst);
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_nonces.size() > 0) begin
					in_valid     <= 1'b1;
					packet_nonce <= pending_nonces.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result beat against the oldest expectation, random stalls
	always @(posedge clk or negedge arst_n) begin : result_monitor
		nonce_verdict_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_stall = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_verdicts.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: unexpected beat, is_new=%b", results_seen, is_new);
				end else begin
					want = expected_verdicts.pop_front();
					beats_in_flight--;
					if (is_new !== want.is_new) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result %0d: nonce %h is_new expected %b, got %b",
								results_seen, want.nonce, want.is_new, is_new);
					end
				end
				results_seen++;
			end
			if ($urandom_range(0, 199) == 0)
				recv_burst = !recv_burst;
			if (recv_stall > 0)
				recv_stall--;
			else if (!recv_burst && $urandom_range(0, 7) == 0)
				recv_stall = draw_idle(1'b0);
			out_ready <= (recv_stall == 0);
		end
	end

	// Watchdog: ends the run when no beat moves on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles = 0;
		end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
			$display("[duplicate_nonce_filter_unit] ERROR");
			$finish;
		end else begin
			idle_cycles++;
		end
	end

	// Stimulus
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner values on an empty history
		foreach (corner_nonces[i])
			queue_nonce(corner_nonces[i]);
		wait_drained();

		// random mix while the history is shallow
		repeat (150)
			queue_nonce(mixed_nonce());
		wait_drained();

		// small batches aimed at the oldest, newest and middle history entries
		repeat (20) begin
			repeat (6)
				queue_nonce(full_history_nonce());
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[duplicate_nonce_filter_unit] OK");
		else
			$display("[duplicate_nonce_filter_unit] ERROR");
		$finish;
	end

endmodule
